// ===== sv/slpg_pkg.sv =====
`default_nettype none

package slpg_pkg;

   typedef enum logic [1:0] {
      PAT_SOLID,
      PAT_BLINK,
      PAT_STROBE,
      PAT_BREATHE
   } pattern_kind_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct packed {
      logic [3:0] status_code;
      logic       handshake_flag;
      logic       rolling_flag;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       pixel_written;
   } rsp_type;

   typedef struct packed {
      pattern_kind_type kind;
      color_type        color;
      logic [9:0]       interval;
   } pattern_entry_type;

   localparam int CODE_COUNT = 16;

   localparam pattern_entry_type CODE_TABLE [CODE_COUNT] = '{
      '{PAT_SOLID,   '{8'd0,   8'd0,   8'd20},  10'd0},
      '{PAT_SOLID,   '{8'd50,  8'd0,   8'd0},   10'd0},
      '{PAT_SOLID,   '{8'd50,  8'd0,   8'd0},   10'd0},
      '{PAT_BLINK,   '{8'd0,   8'd50,  8'd50},  10'd1000},
      '{PAT_BREATHE, '{8'd0,   8'd255, 8'd255}, 10'd0},
      '{PAT_BLINK,   '{8'd0,   8'd255, 8'd0},   10'd300},
      '{PAT_STROBE,  '{8'd255, 8'd0,   8'd0},   10'd0},
      '{PAT_BLINK,   '{8'd255, 8'd200, 8'd0},   10'd500},
      '{PAT_SOLID,   '{8'd100, 8'd0,   8'd200}, 10'd0},
      '{PAT_BLINK,   '{8'd0,   8'd0,   8'd255}, 10'd100},
      '{PAT_SOLID,   '{8'd255, 8'd100, 8'd0},   10'd0},
      '{PAT_SOLID,   '{8'd20,  8'd20,  8'd20},  10'd0},
      '{PAT_STROBE,  '{8'd200, 8'd0,   8'd0},   10'd0},
      '{PAT_BLINK,   '{8'd255, 8'd0,   8'd50},  10'd100},
      '{PAT_BREATHE, '{8'd0,   8'd0,   8'd100}, 10'd0},
      '{PAT_SOLID,   '{8'd5,   8'd5,   8'd5},   10'd0}
   };

   localparam logic [9:0]  ANIM_INTERVAL  = 10'd20;
   localparam logic [9:0]  ROLL_INTERVAL  = 10'd200;
   localparam color_type   ROLL_COLOR     = '{8'd255, 8'd100, 8'd0};

   localparam logic [6:0]  STROBE_PERIOD  = 7'd100;
   localparam logic [6:0]  STROBE_ON_MS   = 7'd20;
   localparam logic [12:0] BREATHE_PERIOD = 13'd4000;

   localparam logic [7:0]  WHEEL_THIRD    = 8'd85;
   localparam logic [7:0]  WHEEL_TWO_THIRD = 8'd170;

endpackage

`default_nettype wire

// ===== sv/slpg_timebase.sv =====
`default_nettype none

module slpg_timebase #(
   parameter int TIME_BITS       = 32,
   parameter int BREATHE_ENTRIES = 256,
   parameter int IDX_BITS        = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   output logic [TIME_BITS-1:0]      tick_time,
   output logic                      strobe_on,
   output logic [IDX_BITS-1:0]       breathe_idx
);

   localparam logic [12:0] ENTRIES     = 13'(BREATHE_ENTRIES);
   localparam logic [12:0] PERIOD      = slpg_pkg::BREATHE_PERIOD;
   localparam logic [12:0] TWO_PERIOD  = 13'(2 * 4000);
   localparam logic [IDX_BITS-1:0] IDX_FIRST = IDX_BITS'(BREATHE_ENTRIES / 4000);
   localparam logic [11:0] ACC_FIRST   = 12'(BREATHE_ENTRIES % 4000);

   // each register holds the value for the tick that comes next
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [6:0]           strobe_ph_ff, strobe_ph_in;
   logic [11:0]          brt_ph_ff, brt_ph_in;
   logic [11:0]          brt_acc_ff, brt_acc_in;
   logic [IDX_BITS-1:0]  brt_idx_ff, brt_idx_in;
   logic [12:0]          acc_sum;

   always_comb begin
      time_in      = time_ff + TIME_BITS'(1);
      strobe_ph_in = (strobe_ph_ff == slpg_pkg::STROBE_PERIOD - 7'd1) ? 7'd0
                                                                    : strobe_ph_ff + 7'd1;
      acc_sum      = {1'b0, brt_acc_ff} + ENTRIES;
      brt_ph_in    = brt_ph_ff + 12'd1;
      if (acc_sum >= TWO_PERIOD) begin
         brt_idx_in = brt_idx_ff + IDX_BITS'(2);
         brt_acc_in = 12'(acc_sum - TWO_PERIOD);
      end else if (acc_sum >= PERIOD) begin
         brt_idx_in = brt_idx_ff + IDX_BITS'(1);
         brt_acc_in = 12'(acc_sum - PERIOD);
      end else begin
         brt_idx_in = brt_idx_ff;
         brt_acc_in = acc_sum[11:0];
      end
      if (brt_ph_ff == 12'(PERIOD - 13'd1)) begin
         brt_ph_in  = '0;
         brt_idx_in = '0;
         brt_acc_in = '0;
      end
      // time wraps to zero, so every phase restarts
      if (time_ff == '1) begin
         strobe_ph_in = '0;
         brt_ph_in    = '0;
         brt_idx_in   = '0;
         brt_acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= TIME_BITS'(1);
         strobe_ph_ff <= 7'd1;
         brt_ph_ff    <= 12'd1;
         brt_acc_ff   <= ACC_FIRST;
         brt_idx_ff   <= IDX_FIRST;
      end else if (advance) begin
         time_ff      <= time_in;
         strobe_ph_ff <= strobe_ph_in;
         brt_ph_ff    <= brt_ph_in;
         brt_acc_ff   <= brt_acc_in;
         brt_idx_ff   <= brt_idx_in;
      end
   end

   assign tick_time   = time_ff;
   assign strobe_on   = strobe_ph_ff < slpg_pkg::STROBE_ON_MS;
   assign breathe_idx = brt_idx_ff;

endmodule

`default_nettype wire

// ===== sv/slpg_breathe.sv =====
`default_nettype none

module slpg_breathe #(
   parameter int BREATHE_ENTRIES = 256,
   parameter int IDX_BITS        = 8
) (
   input  wire logic [IDX_BITS-1:0] breathe_idx,
   input  wire logic [3:0]          status_code,
   output slpg_pkg::color_type      scaled
);

   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] HALF_PI  = PI_Q30 / 64'd2;
   localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
   localparam logic [63:0] FLOOR_C  = (64'd36787944 << 30) / 64'd100000000;
   localparam logic [63:0] SIN_DIV [7]  = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                            64'd156, 64'd210};
   localparam logic [63:0] EXP_DIV [16] = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6,
                                            64'd7, 64'd8, 64'd9, 64'd10, 64'd11, 64'd12,
                                            64'd13, 64'd14, 64'd15, 64'd16};

   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / SIN_DIV[n-1];
         if (n[0]) sum = sum - term;
         else      sum = sum + term;
      end
      return sum;
   endfunction

   function automatic logic [63:0] exp_q30(input logic [63:0] a);
      logic [63:0] term;
      logic [63:0] sum;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int n = 1; n <= 16; n++) begin
         term = ((term * a) >> 30) / EXP_DIV[n-1];
         sum  = sum + term;
      end
      return sum;
   endfunction

   // 2^60 / e by shift and subtract
   function automatic logic [63:0] recip_q60(input logic [63:0] e);
      logic [63:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 60; i >= 0; i--) begin
         rem = {rem[62:0], (i == 60)};
         if (rem >= e) begin
            rem  = rem - e;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [8*BREATHE_ENTRIES-1:0] build_rom();
      logic [8*BREATHE_ENTRIES-1:0] rom;
      logic [63:0] x;
      logic [63:0] e;
      logic [63:0] v;
      logic        neg;
      rom = '0;
      for (int k = 0; k < BREATHE_ENTRIES; k++) begin
         x   = (64'd2 * PI_Q30 * 64'(k)) / 64'(BREATHE_ENTRIES);
         neg = 1'b0;
         if (x >= PI_Q30) begin
            neg = 1'b1;
            x   = x - PI_Q30;
         end
         if (x > HALF_PI) x = PI_Q30 - x;
         e = exp_q30(sin_q30(x));
         if (neg) e = recip_q60(e);
         v = (e > FLOOR_C) ? (((e - FLOOR_C) * 64'd108) >> 30) : 64'd0;
         rom[k*8 +: 8] = (v > 64'd255) ? 8'd255 : v[7:0];
      end
      return rom;
   endfunction

   localparam logic [8*BREATHE_ENTRIES-1:0] BREATHE_ROM = build_rom();

   // c * v / 255, exact for every product of two 8-bit values
   function automatic logic [7:0] scale255(input logic [7:0] c, input logic [7:0] v);
      logic [15:0] prod;
      logic [15:0] sum;
      prod = 16'(c) * 16'(v);
      sum  = prod + {8'd0, prod[15:8]} + 16'd1;
      return sum[15:8];
   endfunction

   logic [7:0]          level;
   slpg_pkg::color_type base;

   always_comb begin
      level        = BREATHE_ROM[{breathe_idx, 3'b000} +: 8];
      base         = slpg_pkg::CODE_TABLE[status_code].color;
      scaled.red   = scale255(base.red, level);
      scaled.green = scale255(base.green, level);
      scaled.blue  = scale255(base.blue, level);
   end

endmodule

`default_nettype wire

// ===== sv/slpg_pattern.sv =====
`default_nettype none

module slpg_pattern #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire slpg_pkg::req_type    req,
   input  wire logic                 led_enable,
   input  wire logic [TIME_BITS-1:0] tick_time,
   input  wire logic                 strobe_on,
   input  wire slpg_pkg::color_type  breathe_color,
   output slpg_pkg::rsp_type         result
);

   function automatic slpg_pkg::color_type wheel(input logic [7:0] pos);
      slpg_pkg::color_type c;
      logic [7:0] p;
      logic [7:0] q;
      logic [9:0] q3;
      p = 8'd255 - pos;
      if (p < slpg_pkg::WHEEL_THIRD) begin
         q  = p;
         q3 = {2'b00, q} + {1'b0, q, 1'b0};
         c  = '{8'd255 - q3[7:0], 8'd0, q3[7:0]};
      end else if (p < slpg_pkg::WHEEL_TWO_THIRD) begin
         q  = p - slpg_pkg::WHEEL_THIRD;
         q3 = {2'b00, q} + {1'b0, q, 1'b0};
         c  = '{8'd0, q3[7:0], 8'd255 - q3[7:0]};
      end else begin
         q  = p - slpg_pkg::WHEEL_TWO_THIRD;
         q3 = {2'b00, q} + {1'b0, q, 1'b0};
         c  = '{q3[7:0], 8'd255 - q3[7:0], 8'd0};
      end
      return c;
   endfunction

   logic [TIME_BITS-1:0]       last_stamp_ff, last_stamp_in;
   logic                       blink_on_ff, blink_on_in;
   logic [7:0]                 wheel_step_ff, wheel_step_in;
   logic [3:0]                 prev_code_ff, prev_code_in;
   slpg_pkg::color_type        held_color_ff, held_color_in;
   logic                       written;
   logic [TIME_BITS-1:0]       elapsed;
   slpg_pkg::pattern_entry_type entry;

   always_comb begin
      last_stamp_in = last_stamp_ff;
      blink_on_in   = blink_on_ff;
      wheel_step_in = wheel_step_ff;
      prev_code_in  = prev_code_ff;
      held_color_in = held_color_ff;
      written       = 1'b0;
      entry         = slpg_pkg::CODE_TABLE[req.status_code];

      if (req.status_code != prev_code_ff) begin
         prev_code_in  = req.status_code;
         last_stamp_in = '0;
         blink_on_in   = 1'b0;
         wheel_step_in = '0;
         held_color_in = '0;
         written       = 1'b1;
      end

      elapsed = tick_time - last_stamp_in;

      if (!led_enable) begin
         held_color_in = '0;
         written       = 1'b1;
      end else if (req.handshake_flag) begin
         if (elapsed > TIME_BITS'(slpg_pkg::ANIM_INTERVAL)) begin
            last_stamp_in = tick_time;
            wheel_step_in = wheel_step_in + 8'd1;
            held_color_in = wheel(wheel_step_in);
            written       = 1'b1;
         end
      end else if (req.rolling_flag) begin
         if (elapsed > TIME_BITS'(slpg_pkg::ROLL_INTERVAL)) begin
            last_stamp_in = tick_time;
            blink_on_in   = !blink_on_in;
            held_color_in = blink_on_in ? slpg_pkg::ROLL_COLOR : '0;
            written       = 1'b1;
         end
      end else begin
         case (entry.kind)
            slpg_pkg::PAT_SOLID: begin
               held_color_in = entry.color;
               written       = 1'b1;
            end
            slpg_pkg::PAT_BLINK: begin
               if (elapsed > TIME_BITS'(entry.interval)) begin
                  last_stamp_in = tick_time;
                  blink_on_in   = !blink_on_in;
                  held_color_in = blink_on_in ? entry.color : '0;
                  written       = 1'b1;
               end
            end
            slpg_pkg::PAT_STROBE: begin
               held_color_in = strobe_on ? entry.color : '0;
               written       = 1'b1;
            end
            slpg_pkg::PAT_BREATHE: begin
               if (elapsed > TIME_BITS'(slpg_pkg::ANIM_INTERVAL)) begin
                  last_stamp_in = tick_time;
                  held_color_in = breathe_color;
                  written       = 1'b1;
               end
            end
            default: begin
               held_color_in = held_color_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         blink_on_ff   <= 1'b0;
         wheel_step_ff <= '0;
         prev_code_ff  <= '0;
         held_color_ff <= '0;
      end else if (advance) begin
         last_stamp_ff <= last_stamp_in;
         blink_on_ff   <= blink_on_in;
         wheel_step_ff <= wheel_step_in;
         prev_code_ff  <= prev_code_in;
         held_color_ff <= held_color_in;
      end
   end

   assign result = '{held_color_in.red, held_color_in.green, held_color_in.blue, written};

endmodule

`default_nettype wire

// ===== sv/status_led_pattern_generator.sv =====
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   slpg_pkg::req_type
// rsp       out        rsp_valid/rsp_stall   slpg_pkg::rsp_type
// csr       in         csr_valid/csr_ready   led_enable, 1 bit
//
// one request per clock while rsp_stall is low; each request gives exactly one response
// a request passes through the request register, then the response register
// the animation state and the time counters update when a request moves
// from the request register into the response register
// rsp_stall holds the response register and backs up into req_stall
// synchronous reset; led_enable resets to one, csr_ready is always high
`default_nettype none

module status_led_pattern_generator #(
   parameter int TIME_BITS       = 32,
   parameter int BREATHE_ENTRIES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire slpg_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output slpg_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);

   localparam int IDX_BITS = $clog2(BREATHE_ENTRIES);

   logic                 req_valid_ff;
   slpg_pkg::req_type    req_data_ff;
   logic                 rsp_valid_ff;
   slpg_pkg::rsp_type    rsp_data_ff;
   logic                 led_enable_ff;
   logic                 out_open;
   logic                 fire;
   logic [TIME_BITS-1:0] tick_time;
   logic                 strobe_on;
   logic [IDX_BITS-1:0]  breathe_idx;
   slpg_pkg::color_type  breathe_color;
   slpg_pkg::rsp_type    result;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && out_open;
   assign req_stall = req_valid_ff && !out_open;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         led_enable_ff <= 1'b1;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (out_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            led_enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   slpg_timebase #(
      .TIME_BITS       (TIME_BITS),
      .BREATHE_ENTRIES (BREATHE_ENTRIES),
      .IDX_BITS        (IDX_BITS)
   ) u_timebase (
      .clock       (clock),
      .reset       (reset),
      .advance     (fire),
      .tick_time   (tick_time),
      .strobe_on   (strobe_on),
      .breathe_idx (breathe_idx)
   );

   slpg_breathe #(
      .BREATHE_ENTRIES (BREATHE_ENTRIES),
      .IDX_BITS        (IDX_BITS)
   ) u_breathe (
      .breathe_idx (breathe_idx),
      .status_code (req_data_ff.status_code),
      .scaled      (breathe_color)
   );

   slpg_pattern #(
      .TIME_BITS (TIME_BITS)
   ) u_pattern (
      .clock         (clock),
      .reset         (reset),
      .advance       (fire),
      .req           (req_data_ff),
      .led_enable    (led_enable_ff),
      .tick_time     (tick_time),
      .strobe_on     (strobe_on),
      .breathe_color (breathe_color),
      .result        (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff)
      else $error("req_stall raised with an empty request register");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("request moved on but no response appeared");

   a_disabled_dark: assert property (@(posedge clock) disable iff (reset)
      fire && !led_enable_ff |=> rsp_data_ff.red == 8'd0 && rsp_data_ff.green == 8'd0
                                 && rsp_data_ff.blue == 8'd0 && rsp_data_ff.pixel_written)
      else $error("disabled led produced a lit or unwritten pixel");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_LEN     = 60;

   localparam slpg_pkg::pattern_entry_type STATUS_PATTERNS [16] = '{
      '{slpg_pkg::PAT_SOLID,   '{8'd0,   8'd0,   8'd20},  10'd0},
      '{slpg_pkg::PAT_SOLID,   '{8'd50,  8'd0,   8'd0},   10'd0},
      '{slpg_pkg::PAT_SOLID,   '{8'd50,  8'd0,   8'd0},   10'd0},
      '{slpg_pkg::PAT_BLINK,   '{8'd0,   8'd50,  8'd50},  10'd1000},
      '{slpg_pkg::PAT_BREATHE, '{8'd0,   8'd255, 8'd255}, 10'd0},
      '{slpg_pkg::PAT_BLINK,   '{8'd0,   8'd255, 8'd0},   10'd300},
      '{slpg_pkg::PAT_STROBE,  '{8'd255, 8'd0,   8'd0},   10'd0},
      '{slpg_pkg::PAT_BLINK,   '{8'd255, 8'd200, 8'd0},   10'd500},
      '{slpg_pkg::PAT_SOLID,   '{8'd100, 8'd0,   8'd200}, 10'd0},
      '{slpg_pkg::PAT_BLINK,   '{8'd0,   8'd0,   8'd255}, 10'd100},
      '{slpg_pkg::PAT_SOLID,   '{8'd255, 8'd100, 8'd0},   10'd0},
      '{slpg_pkg::PAT_SOLID,   '{8'd20,  8'd20,  8'd20},  10'd0},
      '{slpg_pkg::PAT_STROBE,  '{8'd200, 8'd0,   8'd0},   10'd0},
      '{slpg_pkg::PAT_BLINK,   '{8'd255, 8'd0,   8'd50},  10'd100},
      '{slpg_pkg::PAT_BREATHE, '{8'd0,   8'd0,   8'd100}, 10'd0},
      '{slpg_pkg::PAT_SOLID,   '{8'd5,   8'd5,   8'd5},   10'd0}
   };

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   slpg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   slpg_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data = 1'b0;

   slpg_pkg::req_type pending_ticks[$];
   slpg_pkg::rsp_type expected_pixels[$];
   slpg_pkg::rsp_type want;

   logic req_taken = 1'b0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_on = 1'b0;
   int   hold_cycles = 0;
   int   cycle_count = 0;
   int   accepted_count = 0;
   int   checked_count = 0;
   int   error_count = 0;

   // pixel state as the block should hold it
   logic [31:0]         ms_now;
   logic [31:0]         stamp;
   logic                blink_on;
   logic [7:0]          wheel_pos;
   logic [3:0]          last_code;
   slpg_pkg::color_type held_color;
   logic                pixel_shown;
   logic                led_on;
   logic [7:0]          breathe_lut [256];

   status_led_pattern_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned sine_q30(longint unsigned x);
      longint unsigned x2, term, sum;
      int n;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic longint unsigned exp_q30(longint unsigned a);
      longint unsigned term, sum;
      int n;
      term = 64'd1 << 30;
      sum = term;
      for (n = 1; n <= 16; n++) begin
         term = ((term * a) >> 30) / 64'(n);
         sum = sum + term;
      end
      return sum;
   endfunction

   function automatic void build_breathe_lut();
      longint unsigned pi_q30, floor_q30, x, e, v;
      logic neg;
      int k;
      pi_q30 = 64'd3373259426;
      floor_q30 = (64'd36787944 << 30) / 64'd100000000;
      for (k = 0; k < 256; k++) begin
         x = (2 * pi_q30 * 64'(k)) / 64'd256;
         neg = 1'b0;
         if (x >= pi_q30) begin
            neg = 1'b1;
            x = x - pi_q30;
         end
         if (x > pi_q30 / 2) begin
            x = pi_q30 - x;
         end
         e = exp_q30(sine_q30(x));
         if (neg) begin
            e = (64'd1 << 60) / e;
         end
         v = (e > floor_q30) ? (((e - floor_q30) * 64'd108) >> 30) : 64'd0;
         breathe_lut[k] = (v > 255) ? 8'd255 : v[7:0];
      end
   endfunction

   function automatic void set_pixel(slpg_pkg::color_type c);
      held_color = c;
      pixel_shown = 1'b1;
   endfunction

   function automatic slpg_pkg::color_type wheel_color(logic [7:0] pos);
      int p;
      p = 255 - int'(pos);
      if (p < 85) begin
         return '{8'(255 - 3 * p), 8'd0, 8'(3 * p)};
      end
      if (p < 170) begin
         p = p - 85;
         return '{8'd0, 8'(3 * p), 8'(255 - 3 * p)};
      end
      p = p - 170;
      return '{8'(3 * p), 8'(255 - 3 * p), 8'd0};
   endfunction

   function automatic void blink_tick(logic [31:0] t, slpg_pkg::color_type c,
                                      logic [31:0] interval);
      if (t - stamp > interval) begin
         stamp = t;
         blink_on = !blink_on;
         set_pixel(blink_on ? c : slpg_pkg::color_type'('0));
      end
   endfunction

   function automatic slpg_pkg::rsp_type predict_pixel(slpg_pkg::req_type tick);
      slpg_pkg::rsp_type result;
      slpg_pkg::pattern_entry_type pat;
      logic [31:0] t;
      int level, idx;
      pixel_shown = 1'b0;
      ms_now = ms_now + 32'd1;
      t = ms_now;
      if (tick.status_code != last_code) begin
         last_code = tick.status_code;
         stamp = '0;
         blink_on = 1'b0;
         wheel_pos = '0;
         set_pixel('0);
      end
      pat = STATUS_PATTERNS[tick.status_code];
      if (!led_on) begin
         set_pixel('0);
      end else if (tick.handshake_flag) begin
         if (t - stamp > 32'd20) begin
            stamp = t;
            wheel_pos = wheel_pos + 8'd1;
            set_pixel(wheel_color(wheel_pos));
         end
      end else if (tick.rolling_flag) begin
         blink_tick(t, '{8'd255, 8'd100, 8'd0}, 32'd200);
      end else begin
         case (pat.kind)
            slpg_pkg::PAT_SOLID: begin
               set_pixel(pat.color);
            end
            slpg_pkg::PAT_BLINK: begin
               blink_tick(t, pat.color, 32'(pat.interval));
            end
            slpg_pkg::PAT_STROBE: begin
               set_pixel((t % 100 < 20) ? pat.color : slpg_pkg::color_type'('0));
            end
            default: begin
               if (t - stamp > 32'd20) begin
                  idx = int'(((t % 4000) * 256) / 4000);
                  level = int'(breathe_lut[idx]);
                  stamp = t;
                  set_pixel('{8'(int'(pat.color.red) * level / 255),
                              8'(int'(pat.color.green) * level / 255),
                              8'(int'(pat.color.blue) * level / 255)});
               end
            end
         endcase
      end
      result.red = held_color.red;
      result.green = held_color.green;
      result.blue = held_color.blue;
      result.pixel_written = pixel_shown;
      return result;
   endfunction

   task automatic report_mismatch(string what, int got, int exp_value);
      $display("mismatch %s: got %0d, expected %0d (response %0d)",
               what, got, exp_value, checked_count);
      error_count++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with a long hold when asked for
   always @(negedge clock) begin
      if (hold_on && hold_cycles < HOLD_LEN) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         if (!hold_on) begin
            hold_cycles <= 0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected response, pixel_written",
                            int'(rsp_data.pixel_written), 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.red !== want.red) begin
               report_mismatch("red", int'(rsp_data.red), int'(want.red));
            end
            if (rsp_data.green !== want.green) begin
               report_mismatch("green", int'(rsp_data.green), int'(want.green));
            end
            if (rsp_data.blue !== want.blue) begin
               report_mismatch("blue", int'(rsp_data.blue), int'(want.blue));
            end
            if (rsp_data.pixel_written !== want.pixel_written) begin
               report_mismatch("pixel_written", int'(rsp_data.pixel_written),
                               int'(want.pixel_written));
            end
         end
         checked_count++;
      end
      if (!reset && req_valid && !req_stall) begin
         expected_pixels.push_back(predict_pixel(req_data));
         accepted_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_pixels.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_tick(logic [3:0] code, logic hs, logic roll);
      slpg_pkg::req_type tick;
      tick.status_code = code;
      tick.handshake_flag = hs;
      tick.rolling_flag = roll;
      pending_ticks.push_back(tick);
   endtask

   // runs of one status code with random lengths, mixed with noise bursts
   task automatic add_random_ticks(int count);
      int left, len, mode, i, pick;
      logic [3:0] code;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            len = $urandom_range(8, 1);
            mode = 4;
         end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               len = $urandom_range(25, 1);
            end else if (pick < 95) begin
               len = $urandom_range(250, 25);
            end else begin
               len = $urandom_range(1100, 400);
            end
            mode = $urandom_range(3);
         end
         if (len > left) begin
            len = left;
         end
         code = 4'($urandom_range(15));
         for (i = 0; i < len; i++) begin
            case (mode)
               0: add_tick(code, 1'b0, 1'b0);
               1: add_tick(code, 1'b1, 1'($urandom_range(1)));
               2: add_tick(code, 1'b0, 1'b1);
               3: add_tick(code, $urandom_range(9) == 0, $urandom_range(3) == 0);
               default: add_tick(4'($urandom_range(15)), 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
            endcase
         end
         left = left - len;
      end
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_led_enable(logic value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      led_on = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   initial begin
      int code;
      ms_now = '0;
      stamp = '0;
      blink_on = 1'b0;
      wheel_pos = '0;
      last_code = '0;
      held_color = '0;
      pixel_shown = 1'b0;
      led_on = 1'b1;
      build_breathe_lut();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every code, both overrides, override priority
      write_led_enable(1'b1);
      for (code = 0; code < 16; code++) begin
         add_tick(4'(code), 1'b0, 1'b0);
      end
      add_tick(4'd15, 1'b1, 1'b0);
      add_tick(4'd15, 1'b1, 1'b1);
      add_tick(4'd15, 1'b0, 1'b1);
      add_tick(4'd0, 1'b0, 1'b1);
      add_tick(4'd0, 1'b1, 1'b0);
      add_tick(4'd4, 1'b0, 1'b0);
      add_tick(4'd4, 1'b0, 1'b0);
      wait_drained();

      add_random_ticks(350);
      wait_drained();

      // pixel forced dark
      write_led_enable(1'b0);
      set_idling(64, 0);
      add_random_ticks(100);
      wait_drained();

      write_led_enable(1'b1);
      add_random_ticks(300);
      wait_drained();

      set_idling(0, 64);
      add_random_ticks(350);
      wait_drained();

      // long response hold while requests keep coming, then a full drain
      set_idling(0, 9);
      add_random_ticks(150);
      hold_on = 1'b1;
      while (hold_cycles < HOLD_LEN) begin
         @(posedge clock);
      end
      hold_on = 1'b0;
      set_idling(9, 9);
      wait_drained();
      add_random_ticks(150);
      wait_drained();

      $display("%0d ticks sent over six idling phases with led_enable at 1 and 0",
               accepted_count);
      $display("%0d responses checked, %0d mismatches", checked_count, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
